/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define VSPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define VSPS_ASSERT_NEXT(lbl, clk, rstn, cond, outcome, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (outcome)) \
        else $error(msg);

`endif

/* sv/vsps_pkg.sv */
// Shared constants, types and codes for the vertical seam path search.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsps_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 256;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ENERGY_W    = 18;
    // worst path: (MAX_ROWS - 1) rows of full-scale energy
    localparam int COST_W      = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = (ROW_W > COL_W) ? ROW_W + 1 : COL_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int COST_AW     = COL_W + 1;
    localparam int CHOICE_AW   = ROW_W + COL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS   = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_SEARCH = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CH_LEFT  = 2'd0,
        CH_UP    = 2'd1,
        CH_RIGHT = 2'd2
    } t_choice;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                last_col;
        logic                last_row;
    } t_item;

    typedef struct packed {
        logic [ROW_W:0] rows_eff;
        logic [COL_W:0] cols_eff;
        logic           search_max;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/vertical_seam_path_search_top.sv */
// Pixel energies enter a 4-deep queue one per cycle unless it is full; the back end retires one
// per cycle outside traceback. The last pixel of a frame passes stage 1 and the traceback registers
// before the first seam entry; each further entry needs an emit and a step state (choice store read
// per row), and an output stall holds the emit state; the queue is not drained during traceback.
// Reset (synchronous, active low) clears control state and sets 64 rows, 256 columns, min mode;
// the cost and choice stores keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module vertical_seam_path_search_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [vsps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vsps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [vsps_pkg::ENERGY_W-1:0]     i_energy_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [vsps_pkg::ROW_W-1:0]             o_seam_row,
    output logic [vsps_pkg::COL_W-1:0]             o_seam_column,
    output logic                                   o_seam_last
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    vsps_pkg::t_item front_item;
    vsps_pkg::t_item back_item;
    vsps_pkg::t_cfg  cfg;

    vsps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_energy_value (i_energy_value),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item),
        .o_cfg          (cfg)
    );

    vsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (back_item),
        .i_pop   (pop)
    );

    vsps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item_valid  (q_valid),
        .i_item        (back_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_seam_row    (o_seam_row),
        .o_seam_column (o_seam_column),
        .o_seam_last   (o_seam_last)
    );

endmodule

`default_nettype wire

/* sv/vsps_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/vsps_front.sv */
// Front end: configuration registers, raster position counters, item tagging.
// Depends on vsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsps_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [vsps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [vsps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [vsps_pkg::ENERGY_W-1:0]       i_energy_value,
    input  wire logic                                i_q_full,
    output logic                                     o_push,
    output vsps_pkg::t_item                          o_item,
    output vsps_pkg::t_cfg                           o_cfg
);

    logic [vsps_pkg::ROW_W:0]   r_rows_eff;
    logic [vsps_pkg::COL_W:0]   r_cols_eff;
    logic                       r_search_max;
    logic [vsps_pkg::ROW_W-1:0] r_row;
    logic [vsps_pkg::COL_W-1:0] r_col;

    logic [vsps_pkg::ROW_W:0]   rows_wr;
    logic [vsps_pkg::COL_W:0]   cols_wr;
    logic                       last_col;
    logic                       last_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign o_push      = i_in_valid && !i_q_full;

    assign last_col = ((vsps_pkg::COL_W + 1)'(r_col) + (vsps_pkg::COL_W + 1)'(1)) == r_cols_eff;
    assign last_row = ((vsps_pkg::ROW_W + 1)'(r_row) + (vsps_pkg::ROW_W + 1)'(1)) == r_rows_eff;

    // clamp register writes to the supported frame size
    always_comb begin
        rows_wr = i_cfg_data[vsps_pkg::ROW_W:0];
        if (rows_wr < (vsps_pkg::ROW_W + 1)'(2)) begin
            rows_wr = (vsps_pkg::ROW_W + 1)'(2);
        end else if (rows_wr > (vsps_pkg::ROW_W + 1)'(vsps_pkg::MAX_ROWS)) begin
            rows_wr = (vsps_pkg::ROW_W + 1)'(vsps_pkg::MAX_ROWS);
        end
        cols_wr = i_cfg_data[vsps_pkg::COL_W:0];
        if (cols_wr < (vsps_pkg::COL_W + 1)'(1)) begin
            cols_wr = (vsps_pkg::COL_W + 1)'(1);
        end else if (cols_wr > (vsps_pkg::COL_W + 1)'(vsps_pkg::MAX_COLS)) begin
            cols_wr = (vsps_pkg::COL_W + 1)'(vsps_pkg::MAX_COLS);
        end
    end

    always_comb begin
        o_item.energy   = i_energy_value;
        o_item.row      = r_row;
        o_item.col      = r_col;
        o_item.last_col = last_col;
        o_item.last_row = last_row;
        o_cfg.rows_eff   = r_rows_eff;
        o_cfg.cols_eff   = r_cols_eff;
        o_cfg.search_max = r_search_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_eff   <= (vsps_pkg::ROW_W + 1)'(vsps_pkg::MAX_ROWS);
            r_cols_eff   <= (vsps_pkg::COL_W + 1)'(vsps_pkg::MAX_COLS);
            r_search_max <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
        end else if (i_cfg_valid) begin
            // a write to the rows, columns or search register restarts the frame
            case (vsps_pkg::t_cfg_reg'(i_cfg_index))
                vsps_pkg::CFG_ROWS: begin
                    r_rows_eff <= rows_wr;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                vsps_pkg::CFG_COLS: begin
                    r_cols_eff <= cols_wr;
                    r_row      <= '0;
                    r_col      <= '0;
                end
                vsps_pkg::CFG_SEARCH: begin
                    r_search_max <= i_cfg_data[0];
                    r_row        <= '0;
                    r_col        <= '0;
                end
                default: begin
                end
            endcase
        end else if (o_push) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + vsps_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + vsps_pkg::COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/vsps_queue.sv */
// Short request queue between the front end and the back end.
// Depends on vsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsps_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire vsps_pkg::t_item i_item,
    output logic                 o_full,
    output logic                 o_valid,
    output vsps_pkg::t_item      o_item,
    input  wire logic            i_pop
);

    localparam int QA_W = $clog2(vsps_pkg::QUEUE_DEPTH);

    vsps_pkg::t_item   r_mem [vsps_pkg::QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QA_W:0]     r_count;

    assign o_full  = r_count == (QA_W + 1)'(vsps_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QA_W'(vsps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QA_W'(vsps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QA_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QA_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/vsps_back.sv */
// Back end: path cost recurrence over a ping-pong row store, predecessor store,
// bottom row best column, traceback and output register. Depends on vsps_pkg, vsps_ram.
`timescale 1ns / 1ps
`default_nettype none

module vsps_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire vsps_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_item_valid,
    input  wire vsps_pkg::t_item                i_item,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [vsps_pkg::ROW_W-1:0]          o_seam_row,
    output logic [vsps_pkg::COL_W-1:0]          o_seam_column,
    output logic                                o_seam_last
);

    typedef enum logic [1:0] {
        M_RUN,
        M_EMIT,
        M_STEP
    } t_mode;

    t_mode                         r_mode;
    logic                          r_s1_valid;
    vsps_pkg::t_item               r_s1;
    logic [vsps_pkg::COST_W-1:0]   r_win_l;
    logic [vsps_pkg::COST_W-1:0]   r_win_m;
    logic [vsps_pkg::COST_W-1:0]   r_col0;
    logic                          r_byp_hit;
    logic [vsps_pkg::COST_W-1:0]   r_byp_data;
    logic [vsps_pkg::COST_W-1:0]   r_best_cost;
    logic [vsps_pkg::COL_W-1:0]    r_best_col;
    logic [vsps_pkg::ROW_W-1:0]    r_tr_row;
    logic [vsps_pkg::COL_W-1:0]    r_tr_col;
    logic                          r_out_valid;
    logic [vsps_pkg::ROW_W-1:0]    r_out_row;
    logic [vsps_pkg::COL_W-1:0]    r_out_col;
    logic                          r_out_last;

    logic                          s1_frame_end;
    logic                          first_row;
    logic                          cost_re;
    logic                          cost_we;
    logic [vsps_pkg::COST_AW-1:0]  cost_raddr;
    logic [vsps_pkg::COST_AW-1:0]  cost_waddr;
    logic [vsps_pkg::COST_W-1:0]   cost_rdata;
    logic [vsps_pkg::COST_W-1:0]   win_m;
    logic [vsps_pkg::COST_W-1:0]   win_r;
    logic [vsps_pkg::COST_W-1:0]   best;
    vsps_pkg::t_choice             choice;
    logic [vsps_pkg::COST_W-1:0]   n_cost;
    logic                          bot_better;
    logic [vsps_pkg::COL_W-1:0]    fin_col;
    logic                          choice_we;
    logic                          choice_re;
    logic [1:0]                    choice_rdata;
    logic                          emit_load;
    logic [vsps_pkg::COL_W-1:0]    n_tr_col;

    function automatic logic better(input logic [vsps_pkg::COST_W-1:0] cand,
                                    input logic [vsps_pkg::COST_W-1:0] cur,
                                    input logic                        find_max);
        return find_max ? (cand >= cur) : (cand < cur);
    endfunction

    assign s1_frame_end = r_s1_valid && r_s1.last_col && r_s1.last_row;
    assign o_pop        = i_item_valid && (r_mode == M_RUN) && !s1_frame_end;

    // stage 0 fetches the up-right cost of the row above
    assign cost_re    = o_pop && !i_item.last_col;
    assign cost_raddr = {~i_item.row[0], vsps_pkg::COL_W'(i_item.col + vsps_pkg::COL_W'(1))};
    assign cost_we    = r_s1_valid;
    assign cost_waddr = {r_s1.row[0], r_s1.col};

    assign first_row = r_s1.row == '0;
    assign win_m     = (r_s1.col == '0) ? r_col0 : r_win_m;
    assign win_r     = r_byp_hit ? r_byp_data : cost_rdata;

    always_comb begin
        best   = win_m;
        choice = vsps_pkg::CH_UP;
        if (r_s1.col != '0) begin
            best   = r_win_l;
            choice = vsps_pkg::CH_LEFT;
            if (better(win_m, best, i_cfg.search_max)) begin
                best   = win_m;
                choice = vsps_pkg::CH_UP;
            end
        end
        if (!r_s1.last_col && better(win_r, best, i_cfg.search_max)) begin
            best   = win_r;
            choice = vsps_pkg::CH_RIGHT;
        end
        n_cost = first_row ? '0 : best + vsps_pkg::COST_W'(r_s1.energy);
    end

    // bottom row: strict improvement keeps the lowest column on a tie
    assign bot_better = (r_s1.col == '0) ||
                        (i_cfg.search_max ? (n_cost > r_best_cost) : (n_cost < r_best_cost));
    assign fin_col    = bot_better ? r_s1.col : r_best_col;

    assign choice_we = r_s1_valid && !first_row;
    assign emit_load = (r_mode == M_EMIT) && (!r_out_valid || !i_out_stall);
    assign choice_re = emit_load && (r_tr_row != '0);

    always_comb begin
        n_tr_col = r_tr_col;
        case (vsps_pkg::t_choice'(choice_rdata))
            vsps_pkg::CH_LEFT: begin
                if (r_tr_col != '0) begin
                    n_tr_col = r_tr_col - vsps_pkg::COL_W'(1);
                end
            end
            vsps_pkg::CH_UP: begin
                n_tr_col = r_tr_col;
            end
            default: begin
                if ((vsps_pkg::COL_W + 1)'(r_tr_col) + (vsps_pkg::COL_W + 1)'(1) <
                    i_cfg.cols_eff) begin
                    n_tr_col = r_tr_col + vsps_pkg::COL_W'(1);
                end
            end
        endcase
    end

    vsps_ram #(
        .WIDTH (vsps_pkg::COST_W),
        .DEPTH (2 * vsps_pkg::MAX_COLS)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (cost_waddr),
        .i_wdata (n_cost),
        .i_re    (cost_re),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

    vsps_ram #(
        .WIDTH (2),
        .DEPTH (vsps_pkg::MAX_ROWS * vsps_pkg::MAX_COLS)
    ) u_choice_ram (
        .i_clk   (i_clk),
        .i_we    (choice_we),
        .i_waddr ({r_s1.row, r_s1.col}),
        .i_wdata (choice),
        .i_re    (choice_re),
        .i_raddr ({r_tr_row, r_tr_col}),
        .o_rdata (choice_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_RUN;
            r_s1_valid  <= 1'b0;
            r_byp_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop;
            if (o_pop) begin
                r_s1 <= i_item;
            end
            if (cost_re) begin
                // up-right entry still being written by the previous request
                r_byp_hit  <= cost_we && (cost_waddr == cost_raddr);
                r_byp_data <= n_cost;
            end
            if (r_s1_valid) begin
                r_win_l <= win_m;
                r_win_m <= win_r;
                if (r_s1.col == '0) begin
                    r_col0 <= n_cost;
                end
                if (r_s1.last_row && bot_better) begin
                    r_best_cost <= n_cost;
                    r_best_col  <= r_s1.col;
                end
            end
            if (r_out_valid && !i_out_stall && !emit_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_mode)
                M_RUN: begin
                    if (s1_frame_end) begin
                        r_tr_row <= r_s1.row;
                        r_tr_col <= fin_col;
                        r_mode   <= M_EMIT;
                    end
                end
                M_EMIT: begin
                    if (emit_load) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= r_tr_row;
                        r_out_col   <= r_tr_col;
                        r_out_last  <= r_tr_row == '0;
                        r_mode      <= (r_tr_row == '0) ? M_RUN : M_STEP;
                    end
                end
                M_STEP: begin
                    r_tr_col <= n_tr_col;
                    r_tr_row <= r_tr_row - vsps_pkg::ROW_W'(1);
                    r_mode   <= M_EMIT;
                end
                default: begin
                    r_mode <= M_RUN;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_seam_row    = r_out_row;
    assign o_seam_column = r_out_col;
    assign o_seam_last   = r_out_last;

endmodule

`default_nettype wire

/* sv/vsps_checker.sv */
// Port-level checks on the seam output channel, bound to the top level.
// Depends on assert_macros.svh and vsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vsps_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [vsps_pkg::ROW_W-1:0]  o_seam_row,
    input wire logic [vsps_pkg::COL_W-1:0]  o_seam_column,
    input wire logic                        o_seam_last
);

    `VSPS_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "seam request dropped while stalled")

    `VSPS_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_seam_row) && $stable(o_seam_column) && $stable(o_seam_last), "seam payload changed while stalled")

    `VSPS_ASSERT(a_last_at_top, i_clk, i_rst_n, o_out_valid |-> (o_seam_last == (o_seam_row == '0)), "seam_last does not match row zero")

    `VSPS_ASSERT_NEXT(a_row_down, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_seam_last, !o_out_valid || (o_seam_row == $past(o_seam_row) - 1'b1), "seam rows not counting down")

endmodule

bind vertical_seam_path_search_top vsps_checker u_vsps_checker (.*);

`default_nettype wire

/* test/vsps_seam_checker.sv */
// Checker for the vertical seam path search: watches the config, energy and seam channels,
// predicts the seam entries of each frame and compares them in order.
// Depends on vsps_pkg.
`timescale 1ns / 1ps

module vsps_seam_checker
    import vsps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  o_in_stall,
    input  wire logic [ENERGY_W-1:0]   i_energy_value,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [ROW_W-1:0]      o_seam_row,
    input  wire logic [COL_W-1:0]      o_seam_column,
    input  wire logic                  o_seam_last,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_seam_entry;

    logic [6:0]  rows_cfg;
    logic [8:0]  cols_cfg;
    logic        max_mode;
    logic [31:0] cost_above [MAX_COLS];
    logic [31:0] cost_here  [MAX_COLS];
    t_choice     path_choice [MAX_ROWS*MAX_COLS];
    int unsigned cur_row;
    int unsigned cur_col;
    t_seam_entry seam_backlog [$];
    int          fail_total = 0;

    function automatic int unsigned frame_rows();
        if (rows_cfg < 2) return 2;
        if (rows_cfg > MAX_ROWS) return MAX_ROWS;
        return rows_cfg;
    endfunction

    function automatic int unsigned frame_cols();
        if (cols_cfg < 1) return 1;
        if (cols_cfg > MAX_COLS) return MAX_COLS;
        return cols_cfg;
    endfunction

    // later candidates sit further right
    function automatic bit beats(input logic [31:0] cand, input logic [31:0] best);
        return max_mode ? (cand >= best) : (cand < best);
    endfunction

    task automatic emit_seam(input int unsigned nr, input int unsigned nc);
        int unsigned i;
        int unsigned col;
        int unsigned r;
        logic [31:0] best;
        t_seam_entry ent;
        col  = 0;
        best = cost_here[0];
        for (i = 1; i < nc; i++) begin
            if (max_mode ? (cost_here[i] > best) : (cost_here[i] < best)) begin
                best = cost_here[i];
                col  = i;
            end
        end
        for (r = nr; r > 0; r--) begin
            ent.row  = ROW_W'(r - 1);
            ent.col  = COL_W'(col);
            ent.last = (r == 1);
            seam_backlog.push_back(ent);
            if (r > 1) begin
                case (path_choice[(r-1)*MAX_COLS + col])
                    CH_LEFT:  if (col > 0) col--;
                    CH_RIGHT: if (col + 1 < nc) col++;
                    default: ;
                endcase
            end
        end
    endtask

    task automatic take_energy(input logic [ENERGY_W-1:0] e);
        int unsigned nr;
        int unsigned nc;
        int unsigned i;
        logic [31:0] best;
        t_choice     ch;
        nr = frame_rows();
        nc = frame_cols();
        if (cur_row == 0) begin
            cost_here[cur_col] = '0;
        end else begin
            best = cost_above[cur_col];
            ch   = CH_UP;
            if (cur_col > 0) begin
                best = cost_above[cur_col-1];
                ch   = CH_LEFT;
                if (beats(cost_above[cur_col], best)) begin
                    best = cost_above[cur_col];
                    ch   = CH_UP;
                end
            end
            if (cur_col + 1 < nc && beats(cost_above[cur_col+1], best)) begin
                best = cost_above[cur_col+1];
                ch   = CH_RIGHT;
            end
            cost_here[cur_col] = best + 32'(e);
            path_choice[cur_row*MAX_COLS + cur_col] = ch;
        end
        cur_col++;
        if (cur_col >= nc) begin
            for (i = 0; i < nc; i++) cost_above[i] = cost_here[i];
            cur_col = 0;
            cur_row++;
            if (cur_row >= nr) begin
                cur_row = 0;
                emit_seam(nr, nc);
            end
        end
    endtask

    task automatic compare_field(input string fname, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: seam %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_seam_entry due;
        if (!i_rst_n) begin
            rows_cfg = 7'd64;
            cols_cfg = 9'd256;
            max_mode = 1'b0;
            cur_row  = 0;
            cur_col  = 0;
            seam_backlog.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS: begin
                        rows_cfg = i_cfg_data[6:0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    CFG_COLS: begin
                        cols_cfg = i_cfg_data[8:0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    CFG_SEARCH: begin
                        max_mode = i_cfg_data[0];
                        cur_row  = 0;
                        cur_col  = 0;
                    end
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (seam_backlog.size() == 0) begin
                    fail_total++;
                    $display("%0t: seam entry with none due, actual row %0d col %0d last %0d",
                             $time, o_seam_row, o_seam_column, o_seam_last);
                end else begin
                    due = seam_backlog.pop_front();
                    compare_field("row", 8'(due.row), 8'(o_seam_row));
                    compare_field("column", 8'(due.col), 8'(o_seam_column));
                    compare_field("last", 8'(due.last), 8'(o_seam_last));
                end
            end
            if (i_in_valid && !o_in_stall) take_energy(i_energy_value);
        end
        o_pending    <= seam_backlog.size();
        o_fail_count <= fail_total;
    end

endmodule

/* test/tb_top.sv */
// Top of the seam search testbench: clock, reset, config writes, energy requests and
// receiver stalls; verdict from the seam checker. Depends on vsps_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_top;
    import vsps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned LIMIT         = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic [ENERGY_W-1:0]   i_energy_value = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [ROW_W-1:0]      o_seam_row;
    logic [COL_W-1:0]      o_seam_column;
    logic                  o_seam_last;
    int                    fail_count;
    int                    pending;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned big_rows [4] = '{2, 0, 127, 3};
    int unsigned big_cols [4] = '{5, 3, 1, 4};

    vertical_seam_path_search_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_energy_value (i_energy_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seam_row     (o_seam_row),
        .o_seam_column  (o_seam_column),
        .o_seam_last    (o_seam_last)
    );

    vsps_seam_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_energy_value (i_energy_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seam_row     (o_seam_row),
        .o_seam_column  (o_seam_column),
        .o_seam_last    (o_seam_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int unsigned rows_for(input int unsigned v);
        int unsigned r;
        r = v & 32'h7F;
        return (r < 2) ? 2 : (r > MAX_ROWS) ? MAX_ROWS : r;
    endfunction

    function automatic int unsigned cols_for(input int unsigned v);
        int unsigned c;
        c = v & 32'h1FF;
        return (c < 1) ? 1 : (c > MAX_COLS) ? MAX_COLS : c;
    endfunction

    function automatic logic [ENERGY_W-1:0] random_energy();
        case ($urandom_range(3))
            0: return ENERGY_W'($urandom_range(3));
            1: return ENERGY_W'($urandom_range(262143));
            2: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return ENERGY_W'(195075);
                    default: return '1;
                endcase
            end
            default: return ENERGY_W'($urandom_range(195075));
        endcase
    endfunction

    task automatic offer_energy(input logic [ENERGY_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_energy_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned rows_val;
        int unsigned cols_val;
        int unsigned npix;
        int unsigned sent;
        int unsigned phase_items;
        bit          first_frame;
        bit          rewrite;
        bit          broken;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // partial frame at reset size, then abandoned by a write
        offer_energy('1);
        offer_energy('0);
        offer_energy(ENERGY_W'(131072));
        wait_until_idle();
        write_reg(CFG_ROWS, 9'd2);
        // zero columns clamps to one: only the up predecessor exists
        write_reg(CFG_COLS, 9'd0);
        write_reg(CFG_SEARCH, 9'd0);
        offer_energy('1);
        offer_energy('1);
        // three columns, all costs tied, min then max
        wait_until_idle();
        write_reg(CFG_COLS, 9'd3);
        repeat (3) offer_energy('1);
        repeat (3) offer_energy(ENERGY_W'(5));
        wait_until_idle();
        write_reg(CFG_SEARCH, 9'd1);
        repeat (3) offer_energy('1);
        repeat (3) offer_energy(ENERGY_W'(5));
        wait_until_idle();
        write_reg(CFG_UNUSED, 9'h1FF);
        write_reg(CFG_ROWS, 9'd3);
        write_reg(CFG_COLS, 9'd2);
        write_reg(CFG_SEARCH, 9'd0);
        offer_energy('0);
        offer_energy('0);
        offer_energy(ENERGY_W'(7));
        offer_energy(ENERGY_W'(3));
        offer_energy(ENERGY_W'(1));
        offer_energy('1);

        rows_val = 3;
        cols_val = 2;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            phase_items = 0;
            first_frame = 1'b1;
            rewrite     = 1'b0;
            while (phase_items < 20) begin
                if (first_frame || rewrite || $urandom_range(2) == 0) begin
                    if (first_frame) begin
                        rows_val = big_rows[phase];
                        cols_val = big_cols[phase];
                    end else begin
                        rows_val = ($urandom_range(9) == 0) ? $urandom_range(1)
                                                            : $urandom_range(2, 6);
                        cols_val = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    wait_until_idle();
                    if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, 9'($urandom()));
                    write_reg(CFG_ROWS, {2'($urandom_range(3)), 7'(rows_val)});
                    write_reg(CFG_COLS, 9'(cols_val));
                    write_reg(CFG_SEARCH, {8'($urandom()), 1'($urandom_range(1))});
                end
                npix   = rows_for(rows_val) * cols_for(cols_val);
                broken = !first_frame && npix > 1 && $urandom_range(7) == 0;
                sent   = broken ? $urandom_range(1, npix - 1) : npix;
                repeat (sent) offer_energy(random_energy());
                phase_items += sent;
                rewrite     = broken || first_frame;
                first_frame = 1'b0;
                if (!rewrite && $urandom_range(3) == 0) wait_until_idle();
            end
        end

        wait_until_idle();
        repeat (2 * MAX_ROWS + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
